FILE: hw/rtl/fhm_pkg.sv
// Shared types and constants for the FIFO handoff mutex.
package fhm_pkg;

	localparam int NUM_THREADS = 16;
	localparam int TID_W       = 4;
	localparam int IDX_W       = $clog2(NUM_THREADS);
	localparam int CNT_W       = $clog2(NUM_THREADS + 1);

	typedef enum logic [1:0] {
		OP_LOCK   = 2'd0,
		OP_UNLOCK = 2'd1,
		OP_CHECK  = 2'd2
	} op_t;

	typedef enum logic [3:0] {
		ST_ACQUIRED        = 4'd0,
		ST_QUEUED          = 4'd1,
		ST_FREED           = 4'd2,
		ST_HANDOFF         = 4'd3,
		ST_HELD            = 4'd4,
		ST_NOT_HELD        = 4'd5,
		ST_RECURSIVE       = 4'd6,
		ST_NOT_OWNER       = 4'd7,
		ST_ALREADY_WAITING = 4'd8
	} status_t;

	typedef struct packed {
		logic             push;
		logic             pop;
		logic [IDX_W-1:0] tid;
	} fhm_qcmd_t;

	typedef struct packed {
		logic [IDX_W-1:0] head_tid;
		logic [CNT_W-1:0] count;
		logic             waiting;
		logic             full;
	} fhm_qstat_t;

	typedef struct packed {
		status_t          status;
		logic [TID_W-1:0] woken_id;
		logic             owner_valid;
		logic [TID_W-1:0] owner_id;
	} fhm_res_t;

endpackage

FILE: hw/rtl/fifo_handoff_mutex.sv
// Top level of the FIFO handoff mutex: request register, decision, result register.
//
//  channel   handshake            payload
//  request   start / busy         operation, thread_id
//  result    done (one cycle)     status, woken_id, owner_valid, owner_id
//
// A request is taken whenever start is high; busy is always low, so one
// request per cycle is sustained. Its result appears once it has passed
// the request register and the result register. Owner state and
// queue are updated in the cycle the request sits in the request register.
// Reset frees the lock, empties the queue and clears all waiting flags.
// The receiver cannot stall; done lasts exactly one cycle per result.
module fifo_handoff_mutex import fhm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [1:0]       operation,
	input  logic [TID_W-1:0] thread_id,
	output logic             done,
	output logic [3:0]       status,
	output logic [TID_W-1:0] woken_id,
	output logic             owner_valid,
	output logic [TID_W-1:0] owner_id
);

	logic             valid_s1;
	logic [1:0]       op_s1;
	logic [TID_W-1:0] tid_s1;
	logic             valid_s2;
	fhm_res_t         res;
	fhm_res_t         res_s2;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		op_s1  <= operation;
		tid_s1 <= thread_id;
		res_s2 <= res;
	end

	fhm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid     (valid_s1),
		.operation (op_s1),
		.thread_id (tid_s1),
		.res       (res)
	);

	assign done        = valid_s2;
	assign status      = res_s2.status;
	assign woken_id    = res_s2.woken_id;
	assign owner_valid = res_s2.owner_valid;
	assign owner_id    = res_s2.owner_id;

endmodule

FILE: hw/rtl/fhm_queue.sv
// Waiter FIFO with per-thread waiting flags.
module fhm_queue import fhm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  fhm_qcmd_t  cmd,
	output fhm_qstat_t stat
);

	logic [IDX_W-1:0] slot_q [NUM_THREADS];
	logic [IDX_W-1:0] head_q;
	logic [IDX_W-1:0] tail_q;
	logic [CNT_W-1:0] count_q;
	logic [NUM_THREADS-1:0] flags_q;
	logic [IDX_W-1:0] head_tid;

	assign head_tid      = slot_q[head_q];
	assign stat.head_tid = head_tid;
	assign stat.count    = count_q;
	assign stat.waiting  = flags_q[cmd.tid];
	assign stat.full     = (count_q >= CNT_W'(NUM_THREADS));

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			slot_q[tail_q] <= cmd.tid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			flags_q <= '0;
		end else if (cmd.push) begin
			tail_q           <= (tail_q == IDX_W'(NUM_THREADS - 1)) ? '0 : tail_q + 1'b1;
			count_q          <= count_q + 1'b1;
			flags_q[cmd.tid] <= 1'b1;
		end else if (cmd.pop) begin
			head_q            <= (head_q == IDX_W'(NUM_THREADS - 1)) ? '0 : head_q + 1'b1;
			count_q           <= count_q - 1'b1;
			flags_q[head_tid] <= 1'b0;
		end
	end

	a_push_pop_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.push && cmd.pop))
		else $error("queue push and pop in one cycle");

	a_count_flags: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(flags_q) == int'(count_q))
		else $error("waiting flags disagree with queue count");

endmodule

FILE: hw/rtl/fhm_ctrl.sv
// Lock decision logic: owner state and queue commands.
module fhm_ctrl import fhm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid,
	input  logic [1:0]       operation,
	input  logic [TID_W-1:0] thread_id,
	output fhm_res_t         res
);

	logic             lock_busy_q;
	logic [IDX_W-1:0] owner_q;
	logic             lock_busy_d;
	logic [IDX_W-1:0] owner_d;
	logic [IDX_W-1:0] tid;
	logic             mine;
	status_t          status;
	logic [IDX_W-1:0] woken;
	fhm_qcmd_t        qcmd;
	fhm_qstat_t       qstat;

	assign tid  = thread_id[IDX_W-1:0];
	assign mine = lock_busy_q && (owner_q == tid);

	fhm_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (qcmd),
		.stat   (qstat)
	);

	always_comb begin
		lock_busy_d = lock_busy_q;
		owner_d     = owner_q;
		woken       = '0;
		qcmd.push   = 1'b0;
		qcmd.pop    = 1'b0;
		qcmd.tid    = tid;
		unique case (op_t'(operation))
			OP_LOCK: begin
				if (mine) begin
					status = ST_RECURSIVE;
				end else if (qstat.waiting || qstat.full) begin
					status = ST_ALREADY_WAITING;
				end else if (!lock_busy_q) begin
					lock_busy_d = 1'b1;
					owner_d     = tid;
					status      = ST_ACQUIRED;
				end else begin
					qcmd.push = valid;
					status    = ST_QUEUED;
				end
			end
			OP_UNLOCK: begin
				if (!mine) begin
					status = ST_NOT_OWNER;
				end else if (qstat.count != '0) begin
					woken    = qstat.head_tid;
					owner_d  = qstat.head_tid;
					qcmd.pop = valid;
					status   = ST_HANDOFF;
				end else begin
					lock_busy_d = 1'b0;
					status      = ST_FREED;
				end
			end
			default: begin
				status = mine ? ST_HELD : ST_NOT_HELD;
			end
		endcase
		res.status      = status;
		res.woken_id    = TID_W'(woken);
		res.owner_valid = lock_busy_d;
		res.owner_id    = lock_busy_d ? TID_W'(owner_d) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lock_busy_q <= 1'b0;
			owner_q     <= '0;
		end else if (valid) begin
			lock_busy_q <= lock_busy_d;
			owner_q     <= owner_d;
		end
	end

	a_waiters_need_owner: assert property (@(posedge clk) disable iff (!arst_n)
		(qstat.count != '0) |-> lock_busy_q)
		else $error("waiters queued on a free lock");

	a_error_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		valid && (status == ST_RECURSIVE || status == ST_NOT_OWNER ||
		status == ST_ALREADY_WAITING) |=> $stable(lock_busy_q) && $stable(owner_q))
		else $error("error status changed lock state");

endmodule

FILE: verif/tb.sv
// Self-checking testbench for the FIFO handoff mutex: lock, unlock and check traffic.
module tb import fhm_pkg::*;;

	localparam int          ITEM_TARGET  = 920;
	localparam int          STALL_LIMIT  = 200;
	localparam int          SETTLE_TICKS = 8;
	localparam logic [1:0]  OP_ALT_CHECK = 2'd3;

	class mutex_board;
		logic                   held;
		logic [TID_W-1:0]       owner;
		logic [TID_W-1:0]       ring [NUM_THREADS];
		logic [IDX_W-1:0]       head;
		logic [IDX_W-1:0]       tail;
		logic [CNT_W-1:0]       count;
		logic [NUM_THREADS-1:0] waiting;
		fhm_res_t               outcomes [$];
		int                     errors;

		function new();
			held    = 1'b0;
			owner   = '0;
			head    = '0;
			tail    = '0;
			count   = '0;
			waiting = '0;
			errors  = 0;
			foreach (ring[i]) ring[i] = '0;
		endfunction

		function int pending();
			return outcomes.size();
		endfunction

		// Advance the lock state for one accepted request and queue its outcome.
		function void note_request(logic [1:0] op, logic [TID_W-1:0] tid);
			fhm_res_t r;
			logic     mine;
			mine       = held && owner == tid;
			r.woken_id = '0;
			case (op)
				OP_LOCK: begin
					if (mine) begin
						r.status = ST_RECURSIVE;
					end else if (waiting[tid] || count >= NUM_THREADS) begin
						r.status = ST_ALREADY_WAITING;
					end else if (!held) begin
						held     = 1'b1;
						owner    = tid;
						r.status = ST_ACQUIRED;
					end else begin
						ring[tail]   = tid;
						tail         = tail + 1'b1;
						count        = count + 1'b1;
						waiting[tid] = 1'b1;
						r.status     = ST_QUEUED;
					end
				end
				OP_UNLOCK: begin
					if (!mine) begin
						r.status = ST_NOT_OWNER;
					end else if (count > 0) begin
						r.woken_id            = ring[head];
						head                  = head + 1'b1;
						count                 = count - 1'b1;
						waiting[r.woken_id]   = 1'b0;
						owner                 = r.woken_id;
						r.status              = ST_HANDOFF;
					end else begin
						held     = 1'b0;
						r.status = ST_FREED;
					end
				end
				default: begin
					r.status = mine ? ST_HELD : ST_NOT_HELD;
				end
			endcase
			r.owner_valid = held;
			r.owner_id    = held ? owner : '0;
			outcomes.push_back(r);
		endfunction

		function void check_result(logic [3:0] st, logic [TID_W-1:0] wk, logic ov,
				logic [TID_W-1:0] oid);
			fhm_res_t e;
			if (outcomes.size() == 0) begin
				$display("%0t: result with no request outstanding: %0d %0d %0d/%0d",
					$time, st, wk, ov, oid);
				errors++;
				return;
			end
			e = outcomes.pop_front();
			if (st !== e.status) begin
				$display("%0t: status expected %0d actual %0d", $time, e.status, st);
				errors++;
			end
			if (wk !== e.woken_id) begin
				$display("%0t: woken_id expected %0d actual %0d", $time, e.woken_id, wk);
				errors++;
			end
			if (ov !== e.owner_valid) begin
				$display("%0t: owner_valid expected %0d actual %0d", $time, e.owner_valid, ov);
				errors++;
			end
			if (oid !== e.owner_id) begin
				$display("%0t: owner_id expected %0d actual %0d", $time, e.owner_id, oid);
				errors++;
			end
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	logic [1:0]       operation;
	logic [TID_W-1:0] thread_id;
	logic             done;
	logic [3:0]       status;
	logic [TID_W-1:0] woken_id;
	logic             owner_valid;
	logic [TID_W-1:0] owner_id;

	mutex_board board = new();
	bit         no_gaps;
	int         items_sent;
	int         quiet_cycles;

	fifo_handoff_mutex dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.operation   (operation),
		.thread_id   (thread_id),
		.done        (done),
		.status      (status),
		.woken_id    (woken_id),
		.owner_valid (owner_valid),
		.owner_id    (owner_id)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && done) begin
			board.check_result(status, woken_id, owner_valid, owner_id);
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || !arst_n) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Entered just after a falling edge; returns just after the falling edge that
	// follows the transfer.
	task automatic send_req(input logic [1:0] op, input logic [TID_W-1:0] tid);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start     <= 1'b1;
		operation <= op;
		thread_id <= tid;
		do begin
			@(posedge clk);
		end while (busy);
		board.note_request(op, tid);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic wait_for_results();
		start <= 1'b0;
		@(negedge clk);
		while (board.pending() > 0) @(negedge clk);
	endtask

	// Random contention among a window of threads, mostly well-formed lock/unlock pairs.
	task automatic contend(input int n);
		int               pool;
		logic [TID_W-1:0] base;
		logic [TID_W-1:0] tid;
		int               r;
		pool = $urandom_range(2, NUM_THREADS);
		base = TID_W'($urandom_range(0, NUM_THREADS - 1));
		repeat (n) begin
			tid = base + TID_W'($urandom_range(0, pool - 1));
			r   = $urandom_range(0, 99);
			if (r < 45) begin
				send_req(OP_LOCK, tid);
			end else if (r < 80) begin
				if (board.held) send_req(OP_UNLOCK, board.owner);
				else send_req(OP_LOCK, tid);
			end else if (r < 88) begin
				if ($urandom_range(0, 2) == 0 && board.held) tid = board.owner;
				send_req($urandom_range(0, 1) ? OP_CHECK : OP_ALT_CHECK, tid);
			end else if (r < 94) begin
				send_req(OP_UNLOCK, TID_W'($urandom_range(0, NUM_THREADS - 1)));
			end else begin
				if (board.held && $urandom_range(0, 1)) send_req(OP_LOCK, board.owner);
				else send_req(OP_LOCK, TID_W'($urandom_range(0, NUM_THREADS - 1)));
			end
		end
	endtask

	// Every thread contends at once, then ownership is passed down the whole queue.
	task automatic fill_and_drain();
		logic [TID_W-1:0] order [NUM_THREADS];
		logic [TID_W-1:0] t;
		int               j;
		foreach (order[i]) order[i] = TID_W'(i);
		for (int i = NUM_THREADS - 1; i > 0; i--) begin
			j        = $urandom_range(0, i);
			t        = order[i];
			order[i] = order[j];
			order[j] = t;
		end
		foreach (order[i]) send_req(OP_LOCK, order[i]);
		while (board.held) begin
			if ($urandom_range(0, 3) == 0) begin
				send_req(OP_CHECK, TID_W'($urandom_range(0, NUM_THREADS - 1)));
			end
			send_req(OP_UNLOCK, board.owner);
		end
	endtask

	initial begin
		clk          = 1'b0;
		arst_n       = 1'b0;
		start        = 1'b0;
		operation    = OP_LOCK;
		thread_id    = '0;
		no_gaps      = 1'b0;
		items_sent   = 0;
		quiet_cycles = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_req(OP_CHECK, 4'd0);
		send_req(OP_UNLOCK, 4'd15);
		send_req(OP_LOCK, 4'd0);
		send_req(OP_LOCK, 4'd0);
		send_req(OP_CHECK, 4'd0);
		send_req(OP_ALT_CHECK, 4'd15);
		send_req(OP_LOCK, 4'd15);
		send_req(OP_LOCK, 4'd15);
		send_req(OP_LOCK, 4'd9);
		send_req(OP_UNLOCK, 4'd15);
		send_req(OP_UNLOCK, 4'd0);
		send_req(OP_ALT_CHECK, 4'd15);
		send_req(OP_CHECK, 4'd0);
		send_req(OP_UNLOCK, 4'd15);
		send_req(OP_UNLOCK, 4'd9);
		send_req(OP_UNLOCK, 4'd9);
		send_req(OP_LOCK, 4'd15);
		send_req(OP_UNLOCK, 4'd15);
		wait_for_results();

		while (items_sent < ITEM_TARGET) begin
			no_gaps = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 4) == 0) fill_and_drain();
			else contend($urandom_range(20, 40));
			if ($urandom_range(0, 5) == 0) wait_for_results();
		end

		start <= 1'b0;
		@(negedge clk);
		while (board.pending() > 0) @(negedge clk);
		repeat (SETTLE_TICKS) @(negedge clk);
		if (board.errors == 0 && board.pending() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
